@@ hdl/utrs_pkg.sv @@
// Package for the UWB ranging tag sequencer: field widths, codes, reset values
// and the structure of one queued result. Used by every other file in hdl/.
`timescale 1ns / 1ps
package utrs_pkg;

	// Default number of anchors in the ranging round
	localparam int ANCHOR_COUNT_DEF = 3;

	// Field widths
	localparam int TS_W       = 40;
	localparam int ANCHOR_W   = 8;
	localparam int IDX_W      = 4;
	localparam int DIST_W     = 16;
	localparam int ADDR_W     = 16;
	localparam int MS_W       = 16;
	localparam int RETRY_W    = 4;
	localparam int MSG_W      = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 144;

	// Input item kinds
	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_FRAME  = 2'd1,
		KIND_TXDONE = 2'd2,
		KIND_START  = 2'd3
	} kind_t;

	// Result actions
	typedef enum logic [1:0] {
		ACT_POLL   = 2'd0,
		ACT_RANGE  = 2'd1,
		ACT_RXON   = 2'd2,
		ACT_REPORT = 2'd3
	} action_t;

	// Received frame types
	localparam logic [MSG_W-1:0] MSG_POLL_ACK     = 8'd1;
	localparam logic [MSG_W-1:0] MSG_RANGE_REPORT = 8'd3;
	localparam logic [MSG_W-1:0] MSG_RANGE_FAILED = 8'd255;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDRESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLY_DELAY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANT_DELAY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 3'd4;

	// Register reset values
	localparam logic [ADDR_W-1:0]  RST_OWN_ADDRESS = 16'd6;
	localparam logic [MS_W-1:0]    RST_TIMEOUT_MS  = 16'd100;
	localparam logic [TS_W-1:0]    RST_REPLY_DELAY = 40'd51118080;
	localparam logic [DIST_W-1:0]  RST_ANT_DELAY   = 16'd16450;
	localparam logic [RETRY_W-1:0] RST_MAX_RETRIES = 4'd1;

	// Final result of a run (reports, if any, come ahead of it)
	typedef struct packed {
		action_t               action;
		logic [ANCHOR_W-1:0]   anchor;
		logic [TS_W-1:0]       poll_stamp;
		logic [TS_W-1:0]       ack_stamp;
		logic [TS_W-1:0]       send_stamp;
	} head_t;

endpackage

@@ hdl/uwb_ranging_tag_sequencer.sv @@
// Top level of the UWB ranging tag sequencer: input register, sequencing state
// and configuration registers; instantiates utrs_emit. Uses utrs_pkg.
//
// Usage:
//  - s_axis carries events: tuser is the kind (tick, frame, transmit done,
//    start), tdata the frame fields and radio timestamps. cfg_* writes one
//    register per request (index, data); cfg_ready is always high. Write
//    registers only while the block is idle.
//  - m_axis carries commands: tuser is the action, tlast marks the last
//    result of an event. Most events give one result; a round wrap with all
//    anchors valid gives ANCHOR_COUNT reports ahead of the next poll.
//  - Path: an event is captured in the input register, decoded from it
//    and loaded into the run buffer, which offers its first result.
//  - Throughput: one event per cycle while each causes at most one result
//    and m_axis_tready stays high; a run with reports holds the single
//    run buffer in utrs_emit, and new events wait until it is free.
//  - Reset clears sequencing state, stored distances and valid flags, and
//    loads the register defaults. When the receiver stalls, the run buffer
//    holds, then the input register fills and s_axis_tready drops.
`timescale 1ns / 1ps
module uwb_ranging_tag_sequencer #(
	parameter int ANCHOR_COUNT = utrs_pkg::ANCHOR_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// event stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [utrs_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // msg_type, frame_anchor,
	                                                         // target_address, range_dist,
	                                                         // poll_tx_time, ack_rx_time,
	                                                         // system_time
	input  logic [1:0]                        s_axis_tuser,  // kind
	// command stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [utrs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // anchor_number, poll_sent_stamp,
	                                                         // ack_received_stamp,
	                                                         // range_send_stamp, distance_mm
	output logic [1:0]                        m_axis_tuser,  // action
	output logic                              m_axis_tlast,  // last_of_run
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [utrs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [utrs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import utrs_pkg::*;

	localparam int SLOT_W = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;

	// configuration registers
	logic [ADDR_W-1:0]   own_q;
	logic [MS_W-1:0]     timeout_q;
	logic [TS_W-1:0]     reply_q;
	logic [DIST_W-1:0]   ant_q;
	logic [RETRY_W-1:0]  max_retry_q;

	// input register
	logic                v_s1;
	kind_t               kind_s1;
	logic [MSG_W-1:0]    msg_s1;
	logic [ANCHOR_W-1:0] fanchor_s1;
	logic [ADDR_W-1:0]   target_s1;
	logic [DIST_W-1:0]   range_s1;
	logic [TS_W-1:0]     ptx_s1;
	logic [TS_W-1:0]     arx_s1;
	logic [TS_W-1:0]     now_s1;

	// sequencing state
	logic                running_q;
	logic [IDX_W-1:0]    anchor_q;
	logic [RETRY_W-1:0]  retry_q;
	logic [MS_W-1:0]     idle_q;
	logic [DIST_W-1:0]   dist_q [ANCHOR_COUNT];
	logic [ANCHOR_COUNT-1:0] vld_q;

	// next state and run to load
	logic                running_d;
	logic [IDX_W-1:0]    anchor_d;
	logic [RETRY_W-1:0]  retry_d;
	logic [MS_W-1:0]     idle_d;
	logic [DIST_W-1:0]   dist_d [ANCHOR_COUNT];
	logic [ANCHOR_COUNT-1:0] vld_d;
	logic                emit_v;
	logic                rep_d;
	logic                adv;
	head_t               head;

	logic                emit_free;
	logic                proc;
	logic [SLOT_W-1:0]   slot;
	logic                known_msg;
	logic                mismatch;

	assign cfg_ready     = 1'b1;
	assign proc          = v_s1 && emit_free;
	assign s_axis_tready = !v_s1 || emit_free;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q       <= RST_OWN_ADDRESS;
			timeout_q   <= RST_TIMEOUT_MS;
			reply_q     <= RST_REPLY_DELAY;
			ant_q       <= RST_ANT_DELAY;
			max_retry_q <= RST_MAX_RETRIES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OWN_ADDRESS: own_q       <= cfg_data[ADDR_W-1:0];
				REG_TIMEOUT_MS:  timeout_q   <= cfg_data[MS_W-1:0];
				REG_REPLY_DELAY: reply_q     <= cfg_data[TS_W-1:0];
				REG_ANT_DELAY:   ant_q       <= cfg_data[DIST_W-1:0];
				REG_MAX_RETRIES: max_retry_q <= cfg_data[RETRY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			kind_s1    <= kind_t'(s_axis_tuser);
			msg_s1     <= s_axis_tdata[7:0];
			fanchor_s1 <= s_axis_tdata[15:8];
			target_s1  <= s_axis_tdata[31:16];
			range_s1   <= s_axis_tdata[47:32];
			ptx_s1     <= s_axis_tdata[87:48];
			arx_s1     <= s_axis_tdata[127:88];
			now_s1     <= s_axis_tdata[167:128];
		end
	end

	assign slot      = SLOT_W'(anchor_q - IDX_W'(1));
	assign known_msg = (msg_s1 == MSG_POLL_ACK) || (msg_s1 == MSG_RANGE_REPORT) ||
		(msg_s1 == MSG_RANGE_FAILED);
	assign mismatch  = (target_s1 != own_q) || (fanchor_s1 != ANCHOR_W'(anchor_q));

	// event decode and next state
	always_comb begin
		running_d       = running_q;
		anchor_d        = anchor_q;
		retry_d         = retry_q;
		idle_d          = idle_q;
		dist_d          = dist_q;
		vld_d           = vld_q;
		emit_v          = 1'b0;
		rep_d           = 1'b0;
		adv             = 1'b0;
		head            = '0;
		head.action     = ACT_POLL;
		head.anchor     = ANCHOR_W'(anchor_q);

		if (kind_s1 == KIND_START) begin
			running_d = 1'b1;
			idle_d    = '0;
			emit_v    = 1'b1;
		end else if (running_q) begin
			unique case (kind_s1)
				KIND_TICK: begin
					if (idle_q >= timeout_q) begin
						// timeout: drop this anchor's distance, retry or move on
						dist_d[slot] = '0;
						vld_d[slot]  = 1'b0;
						if (retry_q < max_retry_q) begin
							retry_d = retry_q + RETRY_W'(1);
							idle_d  = '0;
							emit_v  = 1'b1;
						end else begin
							adv = 1'b1;
						end
					end else if (idle_q != {MS_W{1'b1}}) begin
						idle_d = idle_q + MS_W'(1);
					end
				end
				KIND_TXDONE: begin
					emit_v      = 1'b1;
					head.action = ACT_RXON;
				end
				KIND_FRAME: begin
					if (known_msg) begin
						if (mismatch) begin
							emit_v      = 1'b1;
							head.action = ACT_RXON;
						end else if (msg_s1 == MSG_POLL_ACK) begin
							idle_d          = '0;
							emit_v          = 1'b1;
							head.action     = ACT_RANGE;
							head.poll_stamp = ptx_s1;
							head.ack_stamp  = arx_s1;
							head.send_stamp = TS_W'(now_s1 + reply_q + TS_W'(ant_q));
						end else begin
							dist_d[slot] = (msg_s1 == MSG_RANGE_REPORT) ? range_s1 : '0;
							vld_d[slot]  = (msg_s1 == MSG_RANGE_REPORT);
							adv          = 1'b1;
						end
					end
				end
				KIND_START: begin
				end
			endcase
		end

		// move to the next anchor; a wrap reports when every anchor is valid
		if (adv) begin
			retry_d     = '0;
			idle_d      = '0;
			emit_v      = 1'b1;
			head.action = ACT_POLL;
			if (anchor_q == IDX_W'(ANCHOR_COUNT)) begin
				anchor_d = IDX_W'(1);
				rep_d    = &vld_d;
			end else begin
				anchor_d = anchor_q + IDX_W'(1);
			end
			head.anchor = ANCHOR_W'(anchor_d);
		end
	end

	// sequencing state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			anchor_q  <= IDX_W'(1);
			retry_q   <= '0;
			idle_q    <= '0;
			vld_q     <= '0;
			for (int i = 0; i < ANCHOR_COUNT; i++) begin
				dist_q[i] <= '0;
			end
		end else if (proc) begin
			running_q <= running_d;
			anchor_q  <= anchor_d;
			retry_q   <= retry_d;
			idle_q    <= idle_d;
			vld_q     <= vld_d;
			dist_q    <= dist_d;
		end
	end

	utrs_emit #(
		.ANCHOR_COUNT (ANCHOR_COUNT)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (proc && emit_v),
		.load_head     (head),
		.load_report   (rep_d),
		.load_dist     (dist_d),
		.free          (emit_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ hdl/utrs_emit.sv @@
// Result run buffer of the ranging tag sequencer: holds one run (optional
// distance reports, then a final command) and plays it out. Uses utrs_pkg.
`timescale 1ns / 1ps
module utrs_emit #(
	parameter int ANCHOR_COUNT = utrs_pkg::ANCHOR_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// load side
	input  logic                              load,
	input  utrs_pkg::head_t                   load_head,
	input  logic                              load_report,
	input  logic [utrs_pkg::DIST_W-1:0]       load_dist [ANCHOR_COUNT],
	output logic                              free,
	// result stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [utrs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // anchor_number, poll_sent_stamp,
	                                                         // ack_received_stamp,
	                                                         // range_send_stamp, distance_mm
	output logic [1:0]                        m_axis_tuser,  // action
	output logic                              m_axis_tlast   // last_of_run
);
	import utrs_pkg::*;

	localparam int SLOT_W = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;

	logic                run_v_q;
	logic                rep_q;
	logic [SLOT_W-1:0]   idx_q;
	head_t               head_q;
	logic [DIST_W-1:0]   snap_q [ANCHOR_COUNT];
	logic                take;

	assign take = m_axis_tvalid && m_axis_tready;
	// buffer can take a new run when empty or when its final result leaves now
	assign free = !run_v_q || (m_axis_tready && !rep_q);

	// control: run occupancy and report walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_v_q <= 1'b0;
			rep_q   <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load && free) begin
				run_v_q <= 1'b1;
				rep_q   <= load_report;
				idx_q   <= '0;
			end else if (take) begin
				if (rep_q) begin
					if (idx_q == SLOT_W'(ANCHOR_COUNT - 1)) begin
						rep_q <= 1'b0;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
					end
				end else begin
					run_v_q <= 1'b0;
				end
			end
		end
	end

	// payload of the run
	always_ff @(posedge clk) begin
		if (load && free) begin
			head_q <= load_head;
			snap_q <= load_dist;
		end
	end

	// output select: report entries first, then the final command
	always_comb begin
		m_axis_tvalid = run_v_q;
		if (rep_q) begin
			m_axis_tuser = ACT_REPORT;
			m_axis_tlast = 1'b0;
			m_axis_tdata = {snap_q[idx_q], {(3 * TS_W){1'b0}},
				ANCHOR_W'(idx_q) + ANCHOR_W'(1)};
		end else begin
			m_axis_tuser = head_q.action;
			m_axis_tlast = 1'b1;
			m_axis_tdata = {{DIST_W{1'b0}}, head_q.send_stamp, head_q.ack_stamp,
				head_q.poll_stamp, head_q.anchor};
		end
	end

endmodule

@@ hdl/utrs_checker.sv @@
// Port-level checks for the UWB ranging tag sequencer, bound to the top
// level. Uses utrs_pkg for action codes.
`timescale 1ns / 1ps
module utrs_checker #(
	parameter int ANCHOR_COUNT = utrs_pkg::ANCHOR_COUNT_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [utrs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic [1:0]                        m_axis_tuser,
	input logic                              m_axis_tlast
);
	import utrs_pkg::*;

	// a distance report never ends a run
	a_report_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ACT_REPORT) |-> !m_axis_tlast)
		else $error("report result marked as last of run");

	// after a report leaves, the run continues with a report or the poll
	a_report_then_poll: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && (m_axis_tuser == ACT_REPORT) |=>
		m_axis_tvalid && ((m_axis_tuser == ACT_REPORT) || (m_axis_tuser == ACT_POLL)))
		else $error("report run not followed by report or poll");

	// timestamps are zero except on a range command
	a_stamps_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ACT_RANGE) |-> (m_axis_tdata[127:8] == '0))
		else $error("timestamps set on a non-range result");

	// anchor numbers stay in 1..ANCHOR_COUNT
	a_anchor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:0] != 8'd0) &&
		(m_axis_tdata[7:0] <= 8'(ANCHOR_COUNT)))
		else $error("anchor number out of range");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled result changed");

endmodule

bind uwb_ranging_tag_sequencer utrs_checker #(
	.ANCHOR_COUNT (ANCHOR_COUNT)
) u_utrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
